/* design/dmvr_pkg.sv */
// Shared types and constants for the display register space with vblank generator.
// Used by the top level, the register memory and the port checker.
`default_nettype none

package dmvr_pkg;

    // default configuration
    localparam int DEF_REG_BYTES           = 4096;
    localparam int DEF_VBLANK_TICKS        = 1024;
    localparam int DEF_STATUS_OFFSET       = 48;
    localparam int DEF_STATUS_CLEAR_OFFSET = 52;
    localparam int DEF_INT_STATUS_OFFSET   = 68;
    localparam int DEF_INT_MASK_OFFSET     = 64;

    // identity region is read-only: 0x00..IDENT_LAST
    localparam logic [15:0] IDENT_LAST = 16'h000F;
    localparam logic [3:0]  MAX_ACCESS = 4'd8;

    // row index into one bank: each bank row holds 8 bytes, banks interleave rows
    localparam int MEM_IDX_W = 12;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] offset;
        logic [3:0]  length;
        logic [63:0] write_data;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [63:0] read_data;
        logic [3:0]  byte_count;
        logic        vblank_irq;
        logic [31:0] vblank_total;
    } t_out;

    // one request to both banks; a cycle carries either a read or byte writes
    typedef struct packed {
        logic                 re;
        logic [MEM_IDX_W-1:0] idx_even;
        logic [MEM_IDX_W-1:0] idx_odd;
        logic [7:0]           be_even;
        logic [7:0]           be_odd;
        logic [63:0]          wdata_even;
        logic [63:0]          wdata_odd;
    } t_mem_req;

    typedef struct packed {
        logic [63:0] rdata_even;
        logic [63:0] rdata_odd;
    } t_mem_rsp;

endpackage

`default_nettype wire

/* design/dmvr_regmem.sv */
// Register byte store: two interleaved banks of 8-byte rows (even and odd rows),
// byte-enable writes, registered read. Depends on dmvr_pkg.
`default_nettype none

module dmvr_regmem
    import dmvr_pkg::*;
#(
    parameter int REG_BYTES = DEF_REG_BYTES
) (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    localparam int NUM_ROWS = (REG_BYTES + 15) / 16;
    localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

    logic [63:0] mem_even [NUM_ROWS];
    logic [63:0] mem_odd  [NUM_ROWS];

    logic [ROW_AW-1:0] idx_even;
    logic [ROW_AW-1:0] idx_odd;

    assign idx_even = i_req.idx_even[ROW_AW-1:0];
    assign idx_odd  = i_req.idx_odd[ROW_AW-1:0];

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 8; b++) begin
            if (i_req.be_even[b]) begin
                mem_even[idx_even][8*b +: 8] <= i_req.wdata_even[8*b +: 8];
            end
            if (i_req.be_odd[b]) begin
                mem_odd[idx_odd][8*b +: 8] <= i_req.wdata_odd[8*b +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rsp.rdata_even <= mem_even[idx_even];
            o_rsp.rdata_odd  <= mem_odd[idx_odd];
        end
    end

endmodule

`default_nettype wire

/* design/display_mmio_vblank_regs_top.sv */
// Top level of the display register space with vblank generator.
// Depends on dmvr_pkg and dmvr_regmem.
`default_nettype none

// A transaction (read, write or tick) runs in two steps: the accept cycle
// issues the read of the two register rows that a valid read can touch, and
// the EXEC state, which waits while the output register holds a stalled
// result, assembles the result, writes any stored bytes back and loads the
// output register. A finished result waits in the output register while the
// next transaction is taken. After reset the block clears its register store,
// one row of each bank per cycle; o_in_stall stays high until the clearing
// pass ends. Vblank pending (status bit 0) and the interrupt-enable bit are
// also held in flops next to the memory.
module display_mmio_vblank_regs_top
    import dmvr_pkg::*;
#(
    parameter int REG_BYTES           = DEF_REG_BYTES,
    parameter int VBLANK_TICKS        = DEF_VBLANK_TICKS,
    parameter int STATUS_OFFSET       = DEF_STATUS_OFFSET,
    parameter int STATUS_CLEAR_OFFSET = DEF_STATUS_CLEAR_OFFSET,
    parameter int INT_STATUS_OFFSET   = DEF_INT_STATUS_OFFSET,
    parameter int INT_MASK_OFFSET     = DEF_INT_MASK_OFFSET
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int NUM_ROWS = (REG_BYTES + 15) / 16;
    localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int TICK_W   = (VBLANK_TICKS > 1) ? $clog2(VBLANK_TICKS) : 1;
    localparam bit STATUS_IN = (STATUS_OFFSET < REG_BYTES);
    localparam bit MASK_IN   = (INT_MASK_OFFSET < REG_BYTES);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    function automatic logic access_ok(input logic [15:0] off, input logic [3:0] len);
        logic [16:0] endp;
        endp = {1'b0, off} + {13'b0, len};
        return (len != 4'd0) && (len <= MAX_ACCESS) &&
               ({1'b0, off} < 17'(REG_BYTES)) && (endp <= 17'(REG_BYTES));
    endfunction

    function automatic logic [7:0] lane_mask(input logic [3:0] len);
        logic [7:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i] = (4'(i) < len);
        end
        return m;
    endfunction

    logic [1:0]        r_state, n_state;
    logic [ROW_AW-1:0] r_clr_idx;
    t_in               r_item;
    t_out              r_out, n_out;
    logic              r_out_valid;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [31:0]       r_total, n_total;
    logic              r_status_bit, n_status_bit;
    logic              r_mask_bit, n_mask_bit;

    logic     accept;
    logic     out_free;
    logic     finish;
    logic     wr_store;
    t_mem_req mreq;
    t_mem_rsp mrsp;

    logic [15:0]  sel_off;
    logic [11:0]  row;
    logic [11:0]  row_nx;
    logic         item_ok;
    logic [7:0]   lmask;
    logic [127:0] rd_win;
    logic [63:0]  rd_bytes;
    logic [63:0]  byte_mask64;
    logic [15:0]  wr_en16;
    logic [127:0] wr_data128;
    logic [16:0]  st_pos;
    logic [16:0]  mk_pos;
    logic         st_cov;
    logic         mk_cov;
    logic         ro_start;
    logic [TICK_W:0] tick_nx;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign finish     = (r_state == ST_EXEC) && out_free;

    assign sel_off = (r_state == ST_EXEC) ? r_item.offset : i_in.offset;
    assign row     = sel_off[15:4];
    assign row_nx  = row + 12'd1;

    dmvr_regmem #(
        .REG_BYTES(REG_BYTES)
    ) u_regmem (
        .i_clk(i_clk),
        .i_req(mreq),
        .o_rsp(mrsp)
    );

    // item decode, evaluated on the registered transaction
    always_comb begin
        item_ok = access_ok(r_item.offset, r_item.length);
        lmask   = lane_mask(r_item.length);
        for (int i = 0; i < 8; i++) begin
            byte_mask64[8*i +: 8] = {8{lmask[i]}};
        end
        st_pos = 17'(STATUS_OFFSET) - {1'b0, r_item.offset};
        mk_pos = 17'(INT_MASK_OFFSET) - {1'b0, r_item.offset};
        st_cov = STATUS_IN && ({1'b0, r_item.offset} <= 17'(STATUS_OFFSET)) &&
                 (st_pos < {13'b0, r_item.length});
        mk_cov = MASK_IN && ({1'b0, r_item.offset} <= 17'(INT_MASK_OFFSET)) &&
                 (mk_pos < {13'b0, r_item.length});
        ro_start = (r_item.offset <= IDENT_LAST) ||
                   (r_item.offset == 16'(STATUS_OFFSET)) ||
                   (r_item.offset == 16'(INT_STATUS_OFFSET));
        wr_store = (r_item.cmd == CMD_WRITE) && item_ok && !ro_start &&
                   (r_item.offset != 16'(STATUS_CLEAR_OFFSET));
        // lower row sits in the odd bank when offset bit 3 is set
        rd_win = r_item.offset[3] ? {mrsp.rdata_even, mrsp.rdata_odd}
                                  : {mrsp.rdata_odd, mrsp.rdata_even};
        rd_win   = rd_win >> {r_item.offset[2:0], 3'b000};
        rd_bytes = rd_win[63:0] & byte_mask64;
        if (st_cov) begin
            rd_bytes[{st_pos[2:0], 3'b000}] = r_status_bit;
        end
        wr_en16    = {8'b0, lmask} << r_item.offset[2:0];
        wr_data128 = {64'b0, r_item.write_data} << {r_item.offset[2:0], 3'b000};
    end

    // memory port: clearing pass, read at accept, byte writes at finish
    always_comb begin
        mreq = '0;
        if (r_state == ST_CLEAR) begin
            mreq.idx_even = MEM_IDX_W'(r_clr_idx);
            mreq.idx_odd  = MEM_IDX_W'(r_clr_idx);
            mreq.be_even  = 8'hFF;
            mreq.be_odd   = 8'hFF;
        end else if (accept) begin
            mreq.re       = (i_in.cmd == CMD_READ) && access_ok(i_in.offset, i_in.length);
            mreq.idx_even = i_in.offset[3] ? row_nx : row;
            mreq.idx_odd  = row;
        end else if (finish && wr_store) begin
            mreq.idx_even = r_item.offset[3] ? row_nx : row;
            mreq.idx_odd  = row;
            if (r_item.offset[3]) begin
                mreq.be_odd     = wr_en16[7:0];
                mreq.wdata_odd  = wr_data128[63:0];
                mreq.be_even    = wr_en16[15:8];
                mreq.wdata_even = wr_data128[127:64];
            end else begin
                mreq.be_even    = wr_en16[7:0];
                mreq.wdata_even = wr_data128[63:0];
                mreq.be_odd     = wr_en16[15:8];
                mreq.wdata_odd  = wr_data128[127:64];
            end
        end
    end

    // result and flop-held state
    always_comb begin
        n_out        = '0;
        n_tick       = r_tick;
        n_total      = r_total;
        n_status_bit = r_status_bit;
        n_mask_bit   = r_mask_bit;
        tick_nx      = {1'b0, r_tick} + {{TICK_W{1'b0}}, 1'b1};
        case (r_item.cmd)
            CMD_READ: begin
                if (item_ok) begin
                    n_out.read_data  = rd_bytes;
                    n_out.byte_count = r_item.length;
                end else begin
                    n_out.status = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (!item_ok) begin
                    n_out.status = 1'b1;
                end else if (wr_store) begin
                    if (st_cov) begin
                        n_status_bit = r_item.write_data[{st_pos[2:0], 3'b000}];
                    end
                    if (mk_cov) begin
                        n_mask_bit = r_item.write_data[{mk_pos[2:0], 3'b000}];
                    end
                end else if (!ro_start && r_item.write_data[0]) begin
                    // status-clear register: write one to clear vblank pending
                    n_status_bit = 1'b0;
                end
            end
            CMD_TICK: begin
                if (tick_nx >= (TICK_W + 1)'(VBLANK_TICKS)) begin
                    n_tick           = '0;
                    n_total          = r_total + 32'd1;
                    n_status_bit     = STATUS_IN;
                    n_out.vblank_irq = r_mask_bit;
                end else begin
                    n_tick = tick_nx[TICK_W-1:0];
                end
            end
            default: begin
            end
        endcase
        n_out.vblank_total = n_total;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == ROW_AW'(NUM_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_idx    <= '0;
            r_out_valid  <= 1'b0;
            r_tick       <= '0;
            r_total      <= '0;
            r_status_bit <= 1'b0;
            r_mask_bit   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + ROW_AW'(1);
            end
            if (finish) begin
                r_out_valid  <= 1'b1;
                r_tick       <= n_tick;
                r_total      <= n_total;
                r_status_bit <= n_status_bit;
                r_mask_bit   <= n_mask_bit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
        if (finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* design/dmvr_checker.sv */
// Port-level checker for the display register block, bound to the top level.
// Depends on dmvr_pkg.
`default_nettype none

module dmvr_checker
    import dmvr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out
);

    // an accepted transaction keeps the input busy for the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // an invalid transaction returns no data
    a_bad_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status |->
            o_out.byte_count == 4'd0 && o_out.read_data == 64'd0 && !o_out.vblank_irq)
        else $error("invalid status with payload");

    // an interrupt pulse only comes with a plain tick result
    a_irq_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.vblank_irq |->
            o_out.byte_count == 4'd0 && o_out.read_data == 64'd0 && !o_out.status)
        else $error("interrupt on non-tick result");

    // byte count stays within MAX_ACCESS, and a zero count returns no read data
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.byte_count <= MAX_ACCESS &&
            (o_out.byte_count != 4'd0 || o_out.read_data == 64'd0))
        else $error("byte count out of range");

endmodule

bind display_mmio_vblank_regs_top dmvr_checker u_dmvr_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out(o_out)
);

`default_nettype wire
